// File: src/diamond_zbuffer_raster_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the diamond z-buffer rasterizer
// Implication checks on the rising edge of clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DIAMOND_ZBUFFER_RASTER_TOP_ASSERT_SVH
`define DIAMOND_ZBUFFER_RASTER_TOP_ASSERT_SVH

// same-cycle implication
`define DZR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DZR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/dzr_pkg.sv
// ----------------------------------------------------------------------------
// dzr_pkg
// Types and constants shared by the diamond z-buffer rasterizer.
// ----------------------------------------------------------------------------
package dzr_pkg;

   localparam int CW = 13;
   localparam int DW = 24;
   localparam int CNT_W = 12;

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic CSR_BG_GLYPH = 1'b0;
   localparam logic CSR_BG_DEPTH = 1'b1;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_DRAW,
      KIND_READ,
      KIND_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [9:0]  pos_x;
      logic signed [9:0]  pos_y;
      logic signed [15:0] depth;
      logic [7:0]         glyph;
      logic [5:0]         half;
      logic [4:0]         read_row;
      logic [5:0]         read_col;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

// File: src/diamond_zbuffer_raster_top.sv
// ----------------------------------------------------------------------------
// diamond_zbuffer_raster_top
// Glyph and depth buffer with diamond rasterizer, cell read and clear.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell RAM once, with busy high and
// csr_ready low. A command is taken when start is high and busy low; up to
// two commands queue ahead of the engine, which runs one command at a time:
// a draw walks each diamond row, reading and then conditionally writing
// each on-screen covered cell; a read issues the address and then returns
// the data; a clear writes every cell. Each command returns exactly one
// beat on rsp_valid; it cannot be held off.
module diamond_zbuffer_raster_top import dzr_pkg::*; #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [9:0]  req_pos_x,
   input  logic signed [9:0]  req_pos_y,
   input  logic signed [15:0] req_shape_depth,
   input  logic [7:0]         req_glyph,
   input  logic [5:0]         req_half_height,
   input  logic [4:0]         req_read_row,
   input  logic [5:0]         req_read_col,
   output logic               rsp_valid,
   output logic [7:0]         rsp_cell_glyph,
   output logic signed [15:0] rsp_cell_depth,
   output logic [11:0]        rsp_cells_written,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);

`include "diamond_zbuffer_raster_top_assert.svh"

   logic [7:0]         bg_glyph_ff;
   logic signed [15:0] bg_depth_ff;
   cmd_type            head;
   q_stat_type         q_stat;
   logic               pop;
   logic               init;
   logic               push;

   assign csr_ready = !init;
   assign push      = start && !busy;
   assign busy      = q_stat.full || init;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_glyph_ff <= 8'd32;
         bg_depth_ff <= 16'sh8000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BG_GLYPH: bg_glyph_ff <= csr_data[7:0];
            CSR_BG_DEPTH: bg_depth_ff <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   dzr_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .op          (req_op),
      .pos_x       (req_pos_x),
      .pos_y       (req_pos_y),
      .shape_depth (req_shape_depth),
      .glyph       (req_glyph),
      .half_height (req_half_height),
      .read_row    (req_read_row),
      .read_col    (req_read_col),
      .pop         (pop),
      .head        (head),
      .stat        (q_stat)
   );

   dzr_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_stat            (q_stat),
      .pop               (pop),
      .bg_glyph          (bg_glyph_ff),
      .bg_depth          (bg_depth_ff),
      .init              (init),
      .rsp_valid         (rsp_valid),
      .rsp_cell_glyph    (rsp_cell_glyph),
      .rsp_cell_depth    (rsp_cell_depth),
      .rsp_cells_written (rsp_cells_written)
   );

   `DZR_ASSERT_NEXT(a_push_queued, push, !q_stat.empty, "accepted command not queued")
   `DZR_ASSERT_NOW(a_no_rsp_in_init, init, !rsp_valid, "result beat during reset sweep")
   `DZR_ASSERT_NOW(a_draw_rsp_clean, rsp_valid && rsp_cells_written != 12'd0, rsp_cell_glyph == 8'd0 && rsp_cell_depth == 16'sd0, "draw beat carries cell data")

endmodule

// File: src/dzr_ram.sv
// ----------------------------------------------------------------------------
// dzr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dzr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: src/dzr_front.sv
// ----------------------------------------------------------------------------
// dzr_front
// Classify incoming commands and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module dzr_front import dzr_pkg::*; #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [1:0]         op,
   input  logic signed [9:0]  pos_x,
   input  logic signed [9:0]  pos_y,
   input  logic signed [15:0] shape_depth,
   input  logic [7:0]         glyph,
   input  logic [5:0]         half_height,
   input  logic [4:0]         read_row,
   input  logic [5:0]         read_col,
   input  logic               pop,
   output cmd_type            head,
   output q_stat_type         stat
);

   cmd_type    entry_ff [2];
   cmd_type    cmd_new;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      cmd_new.pos_x    = pos_x;
      cmd_new.pos_y    = pos_y;
      cmd_new.depth    = shape_depth;
      cmd_new.glyph    = glyph;
      cmd_new.half     = half_height;
      cmd_new.read_row = read_row;
      cmd_new.read_col = read_col;
      unique case (op)
         OP_DRAW:  cmd_new.kind = (half_height == 6'd0) ? KIND_NOP : KIND_DRAW;
         OP_READ:  cmd_new.kind = (32'(read_row) < SCREEN_HEIGHT &&
                                   32'(read_col) < SCREEN_WIDTH) ? KIND_READ : KIND_NOP;
         OP_CLEAR: cmd_new.kind = KIND_CLEAR;
         default:  cmd_new.kind = KIND_NOP;
      endcase
   end

   assign do_push   = push && (count_ff != 2'd2);
   assign do_pop    = pop && (count_ff != 2'd0);
   assign wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == 2'd0);
   assign stat.full  = (count_ff == 2'd2);

endmodule

// File: src/dzr_back.sv
// ----------------------------------------------------------------------------
// dzr_back
// Execute queued commands against the cell RAM: diamond draw, read, clear.
// ----------------------------------------------------------------------------
module dzr_back import dzr_pkg::*; #(
   parameter int SCREEN_WIDTH  = 64,
   parameter int SCREEN_HEIGHT = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  head,
   input  q_stat_type               q_stat,
   output logic                     pop,
   input  logic [7:0]               bg_glyph,
   input  logic signed [15:0]       bg_depth,
   output logic                     init,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_cell_glyph,
   output logic signed [15:0]       rsp_cell_depth,
   output logic [CNT_W-1:0]         rsp_cells_written
);

   localparam int N  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AW = $clog2(N);
   localparam int XW = $clog2(SCREEN_WIDTH);
   localparam int YW = $clog2(SCREEN_HEIGHT);
   localparam logic signed [CW-1:0] W_S = CW'(SCREEN_WIDTH);
   localparam logic signed [CW-1:0] H_S = CW'(SCREEN_HEIGHT);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_ROW      = 7'b0000010,
      S_ISSUE    = 7'b0000100,
      S_CHECK    = 7'b0001000,
      S_RD_ISSUE = 7'b0010000,
      S_RD_DATA  = 7'b0100000,
      S_CLEAR    = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic               init_ff, init_in;
   logic [6:0]         j_ff, j_in;
   logic [XW-1:0]      col_ff, col_in;
   logic [XW-1:0]      end_ff, end_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_glyph_ff, rsp_glyph_in;
   logic signed [15:0] rsp_depth_ff, rsp_depth_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DW-1:0]      wr_data;
   logic [AW-1:0]      rd_addr;
   logic [DW-1:0]      rd_data;

   logic [6:0]         last_j;
   logic [6:0]         half_v;
   logic signed [CW-1:0] y_v, lo_v, hi_v, px_v, half_s;
   logic               visible;
   logic               ge;
   logic [CNT_W-1:0]   count_inc;

   dzr_ram #(.WIDTH(DW), .DEPTH(N)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr = base_ff + AW'(col_ff);
   assign last_j  = {cmd_ff.half, 1'b0} - 7'd2;
   assign half_v  = (j_ff < {1'b0, cmd_ff.half}) ? j_ff : (last_j - j_ff);
   assign half_s  = $signed({{(CW-7){1'b0}}, half_v});
   assign px_v    = CW'(cmd_ff.pos_x);
   assign y_v     = CW'(cmd_ff.pos_y) + $signed({{(CW-7){1'b0}}, j_ff});
   assign lo_v    = px_v - half_s;
   assign hi_v    = px_v + half_s;
   assign visible = !y_v[CW-1] && (y_v < H_S) && !hi_v[CW-1] && (lo_v < W_S);
   assign ge      = cmd_ff.depth >= $signed(rd_data[15:0]);
   assign count_inc = (ge && count_ff != {CNT_W{1'b1}}) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      init_in      = init_ff;
      j_in         = j_ff;
      col_in       = col_ff;
      end_in       = end_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_glyph_in = rsp_glyph_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_count_in = rsp_count_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = {bg_glyph, bg_depth};

      unique case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               unique case (head.kind)
                  KIND_DRAW: begin
                     j_in     = 7'd0;
                     count_in = '0;
                     state_in = S_ROW;
                  end
                  KIND_READ: begin
                     base_in  = AW'(AW'(head.read_row) * AW'(SCREEN_WIDTH));
                     col_in   = XW'(head.read_col);
                     state_in = S_RD_ISSUE;
                  end
                  KIND_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_glyph_in = '0;
                     rsp_depth_in = '0;
                     rsp_count_in = '0;
                  end
               endcase
            end
         end
         S_ROW: begin
            if (visible) begin
               col_in   = lo_v[CW-1] ? '0 : XW'(lo_v);
               end_in   = (hi_v > W_S - 1) ? XW'(SCREEN_WIDTH - 1) : XW'(hi_v);
               base_in  = AW'(AW'(y_v[YW-1:0]) * AW'(SCREEN_WIDTH));
               state_in = S_ISSUE;
            end else if (j_ff == last_j) begin
               rsp_valid_in = 1'b1;
               rsp_glyph_in = '0;
               rsp_depth_in = '0;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end else begin
               j_in = j_ff + 7'd1;
            end
         end
         S_ISSUE: begin
            addr_in  = rd_addr;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            wr_en    = ge;
            wr_addr  = addr_ff;
            wr_data  = {cmd_ff.glyph, cmd_ff.depth};
            count_in = count_inc;
            if (col_ff != end_ff) begin
               col_in   = col_ff + 1'b1;
               state_in = S_ISSUE;
            end else if (j_ff == last_j) begin
               rsp_valid_in = 1'b1;
               rsp_glyph_in = '0;
               rsp_depth_in = '0;
               rsp_count_in = count_inc;
               state_in     = S_IDLE;
            end else begin
               j_in     = j_ff + 7'd1;
               state_in = S_ROW;
            end
         end
         S_RD_ISSUE: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_glyph_in = rd_data[23:16];
            rsp_depth_in = $signed(rd_data[15:0]);
            rsp_count_in = '0;
            state_in     = S_IDLE;
         end
         S_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ff == AW'(N - 1)) begin
               if (!init_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_glyph_in = '0;
                  rsp_depth_in = '0;
                  rsp_count_in = '0;
               end
               init_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      j_ff         <= j_in;
      col_ff       <= col_in;
      end_ff       <= end_in;
      base_ff      <= base_in;
      addr_ff      <= addr_in;
      count_ff     <= count_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign init              = init_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_glyph    = rsp_glyph_ff;
   assign rsp_cell_depth    = rsp_depth_ff;
   assign rsp_cells_written = rsp_count_ff;

endmodule
